FILE: rtl/rtec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtec_pkg
// Shared widths, latencies and types of the radial/along/cross to ECEF
// correction rotation.
// ----------------------------------------------------------------------------
package rtec_pkg;

   // Field widths of the stream payloads.
   localparam int POS_W  = 37;
   localparam int VEL_W  = 25;
   localparam int CORR_W = 19;
   localparam int OUT_W  = 20;

   // Packed payload widths, padded to whole bytes.
   localparam int REQ_W = 248;
   localparam int RSP_W = 64;

   // Internal vector arithmetic.
   localparam int VEC_W     = 62;  // cross product component, signed
   localparam int MAG_W     = 62;  // component magnitude
   localparam int SC_W      = 31;  // block-scaled magnitude
   localparam int SUM_W     = 64;  // sum of squares
   localparam int ROOT_W    = 32;  // integer square root
   localparam int REM_W     = 62;  // division remainder
   localparam int QUO_W     = 31;  // division quotient
   localparam int UQ_W      = 32;  // signed Q30 unit component
   localparam int FRAC_BITS = 30;
   localparam int PROD_W    = 64;  // unit by unit product
   localparam int TERM_W    = 52;  // unit by correction product

   // Pipeline depths.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int UNIT_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int PIPE_LAT   = 2 + UNIT_LAT + 3;

   typedef logic signed [VEC_W-1:0]  vec_comp_type;
   typedef logic signed [UQ_W-1:0]   unit_type;
   typedef logic signed [CORR_W-1:0] corr_type;

endpackage

FILE: rtl/rtec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtec_unit
// Pipelined unit vector in Q30: block scaling, sum of squares, a bit-serial
// square root one step per stage and a restoring divider one quotient bit per
// stage for each of the three components.
// ----------------------------------------------------------------------------
module rtec_unit (
   input  logic                   clock,
   input  logic                   adv,
   input  rtec_pkg::vec_comp_type vec_in   [3],
   output rtec_pkg::unit_type     unit_out [3]
);

   localparam int MAG_W  = rtec_pkg::MAG_W;
   localparam int SC_W   = rtec_pkg::SC_W;
   localparam int SUM_W  = rtec_pkg::SUM_W;
   localparam int ROOT_W = rtec_pkg::ROOT_W;
   localparam int REM_W  = rtec_pkg::REM_W;
   localparam int QUO_W  = rtec_pkg::QUO_W;
   localparam int UQ_W   = rtec_pkg::UQ_W;
   localparam int FB     = rtec_pkg::FRAC_BITS;
   localparam int SQ_N   = rtec_pkg::SQRT_STEPS;
   localparam int DV_N   = rtec_pkg::DIV_STEPS;

   // Stage 1: magnitudes, signs and the largest magnitude.
   logic [MAG_W-1:0] mag_in [3];
   logic [2:0]       neg_in;
   logic [MAG_W-1:0] top_in;
   logic [MAG_W-1:0] mag1_ff [3];
   logic [2:0]       neg1_ff;
   logic [MAG_W-1:0] top1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = vec_in[i][rtec_pkg::VEC_W-1];
         mag_in[i] = neg_in[i] ? MAG_W'(-vec_in[i]) : MAG_W'(vec_in[i]);
      end
      top_in = mag_in[0];
      if (mag_in[1] > top_in) begin
         top_in = mag_in[1];
      end
      if (mag_in[2] > top_in) begin
         top_in = mag_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag1_ff <= mag_in;
         neg1_ff <= neg_in;
         top1_ff <= top_in;
      end
   end

   // Stage 2: bit length of the largest magnitude.
   logic [6:0]       len_in;
   logic [6:0]       len2_ff;
   logic [MAG_W-1:0] mag2_ff [3];
   logic [2:0]       neg2_ff;

   always_comb begin
      len_in = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (top1_ff[b]) begin
            len_in = 7'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len2_ff <= len_in;
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: scale so that the largest magnitude lies in [2^30, 2^31).
   logic [SC_W-1:0] sc_in [3];
   logic [4:0]      lsh;
   logic [4:0]      rsh;
   logic [SC_W-1:0] sc3_ff [3];
   logic [2:0]      neg3_ff;

   always_comb begin
      lsh = 5'(7'(SC_W) - len2_ff);
      rsh = 5'(len2_ff - 7'(SC_W));
      for (int i = 0; i < 3; i++) begin
         if (len2_ff < 7'(SC_W)) begin
            sc_in[i] = SC_W'(mag2_ff[i] << lsh);
         end else begin
            sc_in[i] = SC_W'(mag2_ff[i] >> rsh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc3_ff  <= sc_in;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: squares of the scaled magnitudes.
   logic [2*SC_W-1:0] sq4_ff [3];
   logic [SC_W-1:0]   sc4_ff [3];
   logic [2:0]        neg4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= {{SC_W{1'b0}}, sc3_ff[i]} * {{SC_W{1'b0}}, sc3_ff[i]};
         end
         sc4_ff  <= sc3_ff;
         neg4_ff <= neg3_ff;
      end
   end

   // Stage 5: sum of squares.
   logic [SUM_W-1:0] sum5_ff;
   logic [SC_W-1:0]  sc5_ff [3];
   logic [2:0]       neg5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sum5_ff <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
         sc5_ff  <= sc4_ff;
         neg5_ff <= neg4_ff;
      end
   end

   // Square root, one result bit per stage.
   logic [SUM_W-1:0] srem_ff [SQ_N];
   logic [SUM_W-1:0] sres_ff [SQ_N];
   logic [SC_W-1:0]  ssc_ff  [SQ_N][3];
   logic [2:0]       sneg_ff [SQ_N];

   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      localparam logic [SUM_W-1:0] BIT_J = SUM_W'(1) << (SUM_W - 2 - 2 * j);
      logic [SUM_W-1:0] rem_pre;
      logic [SUM_W-1:0] res_pre;
      logic [SC_W-1:0]  sc_pre [3];
      logic [2:0]       neg_pre;
      logic [SUM_W-1:0] trial;
      logic [SUM_W-1:0] rem_in;
      logic [SUM_W-1:0] res_in;

      if (j == 0) begin : g_first
         assign rem_pre = sum5_ff;
         assign res_pre = '0;
         assign sc_pre  = sc5_ff;
         assign neg_pre = neg5_ff;
      end else begin : g_next
         assign rem_pre = srem_ff[j-1];
         assign res_pre = sres_ff[j-1];
         assign sc_pre  = ssc_ff[j-1];
         assign neg_pre = sneg_ff[j-1];
      end

      always_comb begin
         trial = res_pre + BIT_J;
         if (rem_pre >= trial) begin
            rem_in = rem_pre - trial;
            res_in = (res_pre >> 1) + BIT_J;
         end else begin
            rem_in = rem_pre;
            res_in = res_pre >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            srem_ff[j] <= rem_in;
            sres_ff[j] <= res_in;
            ssc_ff[j]  <= sc_pre;
            sneg_ff[j] <= neg_pre;
         end
      end
   end

   // Division setup: dividend is the scaled magnitude in Q30 plus half the norm.
   logic [ROOT_W-1:0] root;
   logic [REM_W-1:0]  dvrem_ff [3];
   logic [ROOT_W-1:0] dvn_ff;
   logic [2:0]        dvneg_ff;

   assign root = sres_ff[SQ_N-1][ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dvrem_ff[i] <= REM_W'({ssc_ff[SQ_N-1][i], {FB{1'b0}}})
                           + REM_W'(root >> 1);
         end
         dvn_ff   <= root;
         dvneg_ff <= sneg_ff[SQ_N-1];
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   logic [REM_W-1:0]  drem_ff [DV_N][3];
   logic [QUO_W-1:0]  dq_ff   [DV_N][3];
   logic [ROOT_W-1:0] dn_ff   [DV_N];
   logic [2:0]        dneg_ff [DV_N];

   for (genvar k = 0; k < DV_N; k++) begin : g_div
      localparam int SH = DV_N - 1 - k;
      logic [REM_W-1:0]  rem_pre [3];
      logic [QUO_W-1:0]  q_pre   [3];
      logic [ROOT_W-1:0] n_pre;
      logic [2:0]        neg_pre;
      logic [REM_W-1:0]  den;
      logic [REM_W-1:0]  rem_in  [3];
      logic [QUO_W-1:0]  q_in    [3];

      if (k == 0) begin : g_first
         assign rem_pre = dvrem_ff;
         assign q_pre   = '{default: '0};
         assign n_pre   = dvn_ff;
         assign neg_pre = dvneg_ff;
      end else begin : g_next
         assign rem_pre = drem_ff[k-1];
         assign q_pre   = dq_ff[k-1];
         assign n_pre   = dn_ff[k-1];
         assign neg_pre = dneg_ff[k-1];
      end

      always_comb begin
         den = REM_W'(n_pre) << SH;
         for (int i = 0; i < 3; i++) begin
            if (rem_pre[i] >= den) begin
               rem_in[i] = rem_pre[i] - den;
               q_in[i]   = q_pre[i] | (QUO_W'(1) << SH);
            end else begin
               rem_in[i] = rem_pre[i];
               q_in[i]   = q_pre[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[k] <= rem_in;
            dq_ff[k]   <= q_in;
            dn_ff[k]   <= n_pre;
            dneg_ff[k] <= neg_pre;
         end
      end
   end

   // Final stage: restore the component signs.
   rtec_pkg::unit_type unit_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            unit_ff[i] <= dneg_ff[DV_N-1][i] ? -UQ_W'(dq_ff[DV_N-1][i])
                                               : UQ_W'(dq_ff[DV_N-1][i]);
         end
      end
   end

   assign unit_out = unit_ff;

endmodule

FILE: rtl/rac_to_ecef_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rac_to_ecef_correction
// Rotates a radial, along-track, cross-track orbit correction into ECEF using
// the frame spanned by the satellite position and velocity.
// ----------------------------------------------------------------------------
// Usage:
// The req_ stream carries one satellite per transfer: position, velocity and
// the three correction components. The rsp_ stream returns one transfer per
// request, in order: the ECEF correction in 0.1 mm and a flag in rsp_tuser
// that is clear, with a zero vector, when the velocity is zero or the
// position is collinear with the velocity.
// The block takes one transfer every cycle while req_tready is high; each of
// the 75 pipeline stages holds one item and the square root and divider
// advance one bit per stage.
// When the receiver stalls, the pipeline still pushes one more result into a
// skid register behind the output register, then drops req_tready until the
// skid register drains. Nothing is lost or repeated across stalls.
// Reset clears all valid bits, among them those of the output and skid
// registers; data registers are not reset.
// ----------------------------------------------------------------------------
module rac_to_ecef_correction (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, corr_radial, corr_along,
   // corr_cross, zero padding
   input  logic [rtec_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_x, out_y, out_z, zero padding
   output logic [rtec_pkg::RSP_W-1:0]    rsp_tdata,
   // valid_res
   output logic [0:0]                    rsp_tuser
);

   localparam int POS_W  = rtec_pkg::POS_W;
   localparam int VEL_W  = rtec_pkg::VEL_W;
   localparam int CORR_W = rtec_pkg::CORR_W;
   localparam int OUT_W  = rtec_pkg::OUT_W;
   localparam int VEC_W  = rtec_pkg::VEC_W;
   localparam int PROD_W = rtec_pkg::PROD_W;
   localparam int TERM_W = rtec_pkg::TERM_W;
   localparam int UQ_W   = rtec_pkg::UQ_W;
   localparam int FB     = rtec_pkg::FRAC_BITS;
   localparam int ULAT   = rtec_pkg::UNIT_LAT;
   localparam int LAT    = rtec_pkg::PIPE_LAT;
   localparam int RSP_W  = rtec_pkg::RSP_W;

   // Payload unpacking.
   logic signed [POS_W-1:0] pos   [3];
   logic signed [VEL_W-1:0] vel   [3];
   rtec_pkg::corr_type      corr  [3];

   assign pos[0]  = req_tdata[36:0];
   assign pos[1]  = req_tdata[73:37];
   assign pos[2]  = req_tdata[110:74];
   assign vel[0]  = req_tdata[135:111];
   assign vel[1]  = req_tdata[160:136];
   assign vel[2]  = req_tdata[185:161];
   assign corr[0] = req_tdata[204:186];
   assign corr[1] = req_tdata[223:205];
   assign corr[2] = req_tdata[242:224];

   // Global advance: the pipeline moves whenever the skid register is empty.
   logic                adv;
   logic                skid_valid_ff;
   logic [LAT-1:0]      valid_ff;

   assign adv        = !skid_valid_ff;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   // Stage 0: the six products of the position-velocity cross product.
   logic signed [VEC_W-1:0] prod_ff [6];
   logic signed [VEL_W-1:0] vel0_ff [3];
   rtec_pkg::corr_type      k0_ff   [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff[0] <= pos[1] * vel[2];
         prod_ff[1] <= pos[2] * vel[1];
         prod_ff[2] <= pos[2] * vel[0];
         prod_ff[3] <= pos[0] * vel[2];
         prod_ff[4] <= pos[0] * vel[1];
         prod_ff[5] <= pos[1] * vel[0];
         vel0_ff    <= vel;
         k0_ff      <= corr;
      end
   end

   // Stage 1: cross product and the degenerate-frame flag.
   rtec_pkg::vec_comp_type c_in   [3];
   rtec_pkg::vec_comp_type c1_ff  [3];
   rtec_pkg::vec_comp_type v1_ff  [3];
   rtec_pkg::corr_type     k1_ff  [3];
   logic                   bad1_ff;

   always_comb begin
      c_in[0] = prod_ff[0] - prod_ff[1];
      c_in[1] = prod_ff[2] - prod_ff[3];
      c_in[2] = prod_ff[4] - prod_ff[5];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= c_in;
         for (int i = 0; i < 3; i++) begin
            v1_ff[i] <= VEC_W'(vel0_ff[i]);
         end
         k1_ff   <= k0_ff;
         bad1_ff <= (vel0_ff[0] == '0 && vel0_ff[1] == '0 && vel0_ff[2] == '0)
                 || (c_in[0] == '0 && c_in[1] == '0 && c_in[2] == '0);
      end
   end

   // Unit vectors along the velocity and along the orbit normal.
   rtec_pkg::unit_type ea [3];
   rtec_pkg::unit_type ec [3];

   rtec_unit u_along (
      .clock    (clock),
      .adv      (adv),
      .vec_in   (v1_ff),
      .unit_out (ea)
   );

   rtec_unit u_cross (
      .clock    (clock),
      .adv      (adv),
      .vec_in   (c1_ff),
      .unit_out (ec)
   );

   // Delay line that keeps the corrections and the flag beside the units.
   rtec_pkg::corr_type kd_ff   [ULAT][3];
   logic [ULAT-1:0]    badd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         kd_ff[0]   <= k1_ff;
         badd_ff[0] <= bad1_ff;
         for (int j = 1; j < ULAT; j++) begin
            kd_ff[j]   <= kd_ff[j-1];
            badd_ff[j] <= badd_ff[j-1];
         end
      end
   end

   // E1: products for the radial unit vector er = ea x ec.
   logic signed [PROD_W-1:0] xp_ff  [6];
   rtec_pkg::unit_type       ea1_ff [3];
   rtec_pkg::unit_type       ec1_ff [3];
   rtec_pkg::corr_type       ke1_ff [3];
   logic                     bade1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xp_ff[0] <= ea[1] * ec[2];
         xp_ff[1] <= ea[2] * ec[1];
         xp_ff[2] <= ea[2] * ec[0];
         xp_ff[3] <= ea[0] * ec[2];
         xp_ff[4] <= ea[0] * ec[1];
         xp_ff[5] <= ea[1] * ec[0];
         ea1_ff   <= ea;
         ec1_ff   <= ec;
         ke1_ff   <= kd_ff[ULAT-1];
         bade1_ff <= badd_ff[ULAT-1];
      end
   end

   // E2: radial unit vector, rounded from Q60 back to Q30.
   logic signed [PROD_W-1:0] er_rnd [3];
   rtec_pkg::unit_type       er2_ff [3];
   rtec_pkg::unit_type       ea2_ff [3];
   rtec_pkg::unit_type       ec2_ff [3];
   rtec_pkg::corr_type       ke2_ff [3];
   logic                     bade2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         er_rnd[i] = xp_ff[2*i] - xp_ff[2*i+1] + (PROD_W'(1) <<< (FB - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            er2_ff[i] <= UQ_W'(er_rnd[i] >>> FB);
         end
         ea2_ff   <= ea1_ff;
         ec2_ff   <= ec1_ff;
         ke2_ff   <= ke1_ff;
         bade2_ff <= bade1_ff;
      end
   end

   // E3: the nine unit-by-correction terms.
   logic signed [TERM_W-1:0] tp_ff [3][3];
   logic                     bade3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            tp_ff[i][0] <= er2_ff[i] * ke2_ff[0];
            tp_ff[i][1] <= ea2_ff[i] * ke2_ff[1];
            tp_ff[i][2] <= ec2_ff[i] * ke2_ff[2];
         end
         bade3_ff <= bade2_ff;
      end
   end

   // Final sum and rounding, formed as the item leaves the pipeline.
   logic signed [TERM_W-1:0] acc   [3];
   logic [RSP_W-1:0]         res_data;
   logic                     res_flag;
   logic                     push;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = tp_ff[i][0] + tp_ff[i][1] + tp_ff[i][2]
                + (TERM_W'(1) <<< (FB - 1));
      end
      res_data = '0;
      res_flag = !bade3_ff;
      if (!bade3_ff) begin
         for (int i = 0; i < 3; i++) begin
            res_data[i*OUT_W +: OUT_W] = OUT_W'(acc[i] >>> FB);
         end
      end
   end

   assign push = adv && valid_ff[LAT-1];

   // Output register with a skid register behind it.
   logic             out_valid_ff;
   logic [RSP_W-1:0] out_data_ff;
   logic             out_flag_ff;
   logic [RSP_W-1:0] skid_data_ff;
   logic             skid_flag_ff;
   logic             out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            out_flag_ff <= skid_flag_ff;
         end else begin
            out_data_ff <= res_data;
            out_flag_ff <= res_flag;
         end
      end else if (push) begin
         skid_data_ff <= res_data;
         skid_flag_ff <= res_flag;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_flag_ff;

`ifndef ASSERT_OFF
   // The skid register only holds an item while the output register is full.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register valid while output register empty");

   // The skid register fills only after a stalled output transfer.
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("skid register filled without a stall");

   // A degenerate frame returns a zero vector.
   a_bad_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("degenerate frame with nonzero correction");
`endif

endmodule
